// ===== rtl/core/nsc_pkg.sv =====
// Shared types, character codes and decode helpers for the sentence checker.
// No dependencies; every other file except nsc_in_reg imports this package.
`timescale 1ns / 1ps

package nsc_pkg;

  // Counter width of the per-type sentence counters
  localparam int COUNT_WIDTH = 16;
  localparam int TITLE_LEN   = 5;
  localparam int TITLE_BITS  = 8 * TITLE_LEN;
  localparam int NUM_TITLES  = 5;

  // Framing and digit characters
  localparam logic [7:0] CH_DOLLAR  = 8'd36;
  localparam logic [7:0] CH_STAR    = 8'd42;
  localparam logic [7:0] CH_COMMA   = 8'd44;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_F = 8'd70;
  localparam logic [7:0] HEX_A_OFFS = 8'd55;

  // Known titles, first character in the low byte
  localparam logic [TITLE_BITS-1:0] KNOWN_TITLE [NUM_TITLES] = '{
    40'("0VWUP"),
    40'("EVWUP"),
    40'("7VWUP"),
    40'("4VWUP"),
    40'("3VWUP")
  };

  typedef enum logic [2:0] {
    ST_PUWV0 = 3'd0,
    ST_PUWVE = 3'd1,
    ST_PUWV7 = 3'd2,
    ST_PUWV4 = 3'd3,
    ST_PUWV3 = 3'd4,
    ST_OTHER = 3'd5
  } sent_type_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_HEX1 = 2'd2,
    PH_HEX2 = 2'd3
  } phase_t;

  // One checked sentence
  typedef struct packed {
    sent_type_t  sentence_type;
    logic        checksum_ok;
    logic [7:0]  computed_sum;
    logic [7:0]  received_sum;
    logic [3:0]  first_digit;
    logic [3:0]  second_digit;
    logic [15:0] type_count;
  } nsc_result_t;

  // Decimal digit value, zero when not '0'..'9'
  function automatic logic [3:0] as_digit(input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    if (c >= CH_ZERO && c <= CH_NINE) return d[3:0];
    return 4'd0;
  endfunction

  // Uppercase hex value; bit 4 flags a non-hex character
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    logic [7:0] a;
    d = c - CH_ZERO;
    a = c - HEX_A_OFFS;
    if (c >= CH_ZERO && c <= CH_NINE) return {1'b0, d[3:0]};
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return {1'b0, a[3:0]};
    return 5'h10;
  endfunction

  // Match the collected title against the known set
  function automatic sent_type_t classify(input logic [TITLE_BITS-1:0] title,
                                          input logic [2:0] len);
    sent_type_t res;
    res = ST_OTHER;
    if (len == 3'(TITLE_LEN)) begin
      for (int t = NUM_TITLES - 1; t >= 0; t--) begin
        if (title == KNOWN_TITLE[t]) res = sent_type_t'(3'(t));
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/nsc_in_reg.sv =====
// Input register: holds one received byte until the parser takes it.
// Self-contained; uses no package types.
`timescale 1ns / 1ps

module nsc_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  // Stall only while a held byte cannot move on
  assign in_stall = byte_valid && !advance;

  // Load a new beat or drain the held one
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      byte_valid <= 1'b1;
    end else if (advance) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_data <= rx_byte;
    end
  end

endmodule

// ===== rtl/core/nsc_parser.sv =====
// Sentence parser: running XOR, title capture, field digits, hex checksum
// and per-type counters. Depends on nsc_pkg.
`timescale 1ns / 1ps

module nsc_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          c,
  output logic                emit,
  output nsc_pkg::nsc_result_t result
);
  import nsc_pkg::*;

  phase_t                  phase, phase_next;
  logic [7:0]              xor_acc, xor_acc_next;
  logic [TITLE_BITS-1:0]   title_chars, title_chars_next;
  logic [2:0]              title_len, title_len_next;
  logic [1:0]              comma_seen, comma_seen_next;
  logic                    field_start, field_start_next;
  logic [3:0]              digit_one, digit_one_next;
  logic [3:0]              digit_two, digit_two_next;
  logic [4:0]              high_nibble, high_nibble_next;
  logic [COUNT_WIDTH-1:0]  cmd_two_count, cmd_two_count_next;
  logic [COUNT_WIDTH-1:0]  ch4_count, ch4_count_next;
  logic [COUNT_WIDTH-1:0]  ch3_count, ch3_count_next;

  logic [4:0]       low_nibble;
  logic [7:0]       rsum;
  logic             ok;
  sent_type_t       stype;
  logic [COUNT_WIDTH-1:0] cnt;

  // Checksum compare and title decode for the closing digit
  always_comb begin
    low_nibble = hex_value(c);
    rsum       = {high_nibble[3:0], low_nibble[3:0]};
    ok         = !(high_nibble[4] || low_nibble[4]) && (rsum == xor_acc);
    stype      = classify(title_chars, title_len);
  end

  // Next state of the sentence walk
  always_comb begin
    phase_next         = phase;
    xor_acc_next       = xor_acc;
    title_chars_next   = title_chars;
    title_len_next     = title_len;
    comma_seen_next    = comma_seen;
    field_start_next   = field_start;
    digit_one_next     = digit_one;
    digit_two_next     = digit_two;
    high_nibble_next   = high_nibble;
    cmd_two_count_next = cmd_two_count;
    ch4_count_next     = ch4_count;
    ch3_count_next     = ch3_count;

    if (c == CH_DOLLAR) begin
      // Restart, dropping any partial sentence
      phase_next       = PH_BODY;
      xor_acc_next     = '0;
      title_chars_next = '0;
      title_len_next   = '0;
      comma_seen_next  = '0;
      field_start_next = 1'b0;
      digit_one_next   = '0;
      digit_two_next   = '0;
      high_nibble_next = '0;
    end else begin
      case (phase)
        PH_IDLE: begin
          phase_next = PH_IDLE;
        end
        PH_BODY: begin
          if (c == CH_STAR) begin
            phase_next = PH_HEX1;
          end else begin
            xor_acc_next = xor_acc ^ c;
            if (title_len < 3'(TITLE_LEN)) begin
              for (int k = 0; k < TITLE_LEN; k++) begin
                if (title_len == 3'(k)) title_chars_next[8*k +: 8] = c;
              end
              title_len_next = title_len + 3'd1;
            end
            if (field_start) begin
              if (c != CH_COMMA) begin
                if (comma_seen == 2'd1) digit_one_next = as_digit(c);
                else digit_two_next = as_digit(c);
              end
              field_start_next = 1'b0;
            end
            if (c == CH_COMMA && comma_seen < 2'd2) begin
              comma_seen_next  = comma_seen + 2'd1;
              field_start_next = 1'b1;
            end
          end
        end
        PH_HEX1: begin
          high_nibble_next = hex_value(c);
          phase_next       = PH_HEX2;
        end
        PH_HEX2: begin
          phase_next = PH_IDLE;
          case (stype)
            ST_PUWV0: begin
              if (ok && digit_one == 4'd2) cmd_two_count_next = cmd_two_count + 1'b1;
            end
            ST_PUWV4: begin
              if (ok) ch4_count_next = ch4_count + 1'b1;
            end
            ST_PUWV3: begin
              if (ok) ch3_count_next = ch3_count + 1'b1;
            end
            default: begin
            end
          endcase
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // Flag the closing digit and pick the counter it reports
  always_comb begin
    emit = (c != CH_DOLLAR) && (phase == PH_HEX2);
    case (stype)
      ST_PUWV0: cnt = cmd_two_count_next;
      ST_PUWV4: cnt = ch4_count_next;
      ST_PUWV3: cnt = ch3_count_next;
      default:  cnt = '0;
    endcase
  end

  // Pack the result beat
  always_comb begin
    result.sentence_type = stype;
    result.checksum_ok   = ok;
    result.computed_sum  = xor_acc;
    result.received_sum  = rsum;
    result.first_digit   = digit_one;
    result.second_digit  = digit_two;
    result.type_count    = 16'(cnt);
  end

  // Control state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      cmd_two_count <= '0;
      ch4_count     <= '0;
      ch3_count     <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      cmd_two_count <= cmd_two_count_next;
      ch4_count     <= ch4_count_next;
      ch3_count     <= ch3_count_next;
    end
  end

  // Per-sentence payload, rebuilt on every dollar
  always_ff @(posedge clk) begin
    if (fire) begin
      xor_acc     <= xor_acc_next;
      title_chars <= title_chars_next;
      title_len   <= title_len_next;
      comma_seen  <= comma_seen_next;
      field_start <= field_start_next;
      digit_one   <= digit_one_next;
      digit_two   <= digit_two_next;
      high_nibble <= high_nibble_next;
    end
  end

endmodule

// ===== rtl/core/nsc_out_reg.sv =====
// Result register: holds one result beat until the consumer takes it.
// Depends on nsc_pkg for the result struct.
`timescale 1ns / 1ps

module nsc_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  nsc_pkg::nsc_result_t result_in,
  output logic                out_valid,
  input  logic                out_stall,
  output nsc_pkg::nsc_result_t result_out
);
  import nsc_pkg::*;

  // Fill on a new result, empty once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

// ===== rtl/core/nmea_sentence_checker.sv =====
// Checks modem sentences byte by byte. A received byte enters an input
// register and is parsed in the next stage, whose result beat for the
// closing checksum digit is loaded into the result register. One byte
// is accepted every cycle for as long as the result register is free or
// being emptied; a stalled result holds back the byte stream. A dollar
// always restarts a sentence, bytes outside a sentence give no result, and
// a non-hex checksum digit counts as a mismatch. Counters for PUWV0 with
// command 2, PUWV4 and PUWV3 count sentences with a good checksum and wrap.
// Depends on nsc_pkg, nsc_in_reg, nsc_parser and nsc_out_reg.
`timescale 1ns / 1ps

module nmea_sentence_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  sentence_type,
  output logic        checksum_ok,
  output logic [7:0]  computed_sum,
  output logic [7:0]  received_sum,
  output logic [3:0]  first_digit,
  output logic [3:0]  second_digit,
  output logic [15:0] type_count
);
  import nsc_pkg::*;

  logic        byte_valid;
  logic [7:0]  byte_data;
  logic        advance;
  logic        emit;
  nsc_result_t result_next;
  nsc_result_t result;

  // Move the held byte when the result slot is free or draining
  assign advance = byte_valid && (!out_valid || !out_stall);

  nsc_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  nsc_parser u_parse (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .c      (byte_data),
    .emit   (emit),
    .result (result_next)
  );

  nsc_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (advance && emit),
    .result_in  (result_next),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result_out (result)
  );

  // Unpack the result beat
  assign sentence_type = result.sentence_type;
  assign checksum_ok   = result.checksum_ok;
  assign computed_sum  = result.computed_sum;
  assign received_sum  = result.received_sum;
  assign first_digit   = result.first_digit;
  assign second_digit  = result.second_digit;
  assign type_count    = result.type_count;

endmodule

// ===== rtl/core/nsc_checker.sv =====
// Port-level checker for the sentence checker, bound to the top level.
// Depends on nsc_pkg for the type codes and on the top level's ports.
`timescale 1ns / 1ps

module nsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  sentence_type,
  input logic        checksum_ok,
  input logic [7:0]  computed_sum,
  input logic [7:0]  received_sum,
  input logic [3:0]  first_digit,
  input logic [3:0]  second_digit,
  input logic [15:0] type_count
);
  import nsc_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(computed_sum)
      && $stable(received_sum) && $stable(type_count))
    else $error("stalled result beat changed");

  // Back up the input only behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the result side is free");

  // A good checksum means both sums agree
  a_ok_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && checksum_ok |-> computed_sum == received_sum)
    else $error("checksum_ok with differing sums");

  // Titles without a counter report zero
  a_no_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (sentence_type == ST_PUWVE || sentence_type == ST_PUWV7
      || sentence_type == ST_OTHER) |-> type_count == 16'd0)
    else $error("nonzero count for uncounted title");

  // Field digits stay decimal and the type code stays in range
  a_digits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> first_digit <= 4'd9 && second_digit <= 4'd9
      && sentence_type <= ST_OTHER)
    else $error("field digit or type out of range");

endmodule

bind nmea_sentence_checker nsc_checker u_nsc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .sentence_type (sentence_type),
  .checksum_ok   (checksum_ok),
  .computed_sum  (computed_sum),
  .received_sum  (received_sum),
  .first_digit   (first_digit),
  .second_digit  (second_digit),
  .type_count    (type_count)
);

// ===== tb/tb_nmea_sentence_checker.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for nmea_sentence_checker: feeds byte streams of
// sentences, noise and broken frames and checks every result beat.
// Depends on nsc_pkg and the nmea_sentence_checker RTL.

module tb_nmea_sentence_checker;
  import nsc_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 9;
  localparam int MAX_BODY     = 32;
  localparam int RANDOM_BYTES = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int MAX_REPORTS  = 10;
  localparam logic [7:0] CASE_SHIFT = 8'd32;

  typedef enum int {CS_GOOD, CS_WRONG, CS_LOWER, CS_JUNK} sum_mode_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  sentence_type;
  logic        checksum_ok;
  logic [7:0]  computed_sum;
  logic [7:0]  received_sum;
  logic [3:0]  first_digit;
  logic [3:0]  second_digit;
  logic [15:0] type_count;

  nmea_sentence_checker uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sentence_type (sentence_type),
    .checksum_ok   (checksum_ok),
    .computed_sum  (computed_sum),
    .received_sum  (received_sum),
    .first_digit   (first_digit),
    .second_digit  (second_digit),
    .type_count    (type_count)
  );

  // Sentence tracker state, mirrors what the block should hold
  phase_t                 sent_phase;
  logic [7:0]             run_xor;
  logic [7:0]             title_buf [TITLE_LEN];
  int                     title_cnt;
  int                     commas;
  bit                     at_field_start;
  logic [3:0]             field1_digit;
  logic [3:0]             field2_digit;
  logic [4:0]             hi_nibble;
  logic [COUNT_WIDTH-1:0] cmd2_count;
  logic [COUNT_WIDTH-1:0] puwv4_count;
  logic [COUNT_WIDTH-1:0] puwv3_count;

  nsc_result_t expected_sentences [$];

  // Frame under construction for the sender
  logic [7:0] frame_buf [MAX_BODY];
  int         frame_len;
  string      title_text [5] = '{"PUWV0", "PUWVE", "PUWV7", "PUWV4", "PUWV3"};

  // Run control and statistics
  bit src_idle_on;
  bit sink_idle_on;
  int hold_request;
  int cycle_count;
  int total_bytes;
  int live_bytes;
  int results_seen;
  int good_seen;
  int mismatches;
  int type_hits [6];

  // Clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results pending", cycle_count,
                 expected_sentences.size());
        $display("nmea_sentence_checker: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sentence tracker
  // ---------------------------------------------------------------------

  function automatic logic [3:0] digit_of(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return 4'(c - CH_ZERO);
    return 4'd0;
  endfunction

  // Bit 4 flags a character that is not an uppercase hex digit
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return {1'b0, 4'(c - CH_ZERO)};
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return {1'b0, 4'(c - CH_UPPER_A + 8'd10)};
    return 5'h10;
  endfunction

  function automatic sent_type_t title_type();
    if (title_cnt < TITLE_LEN) return ST_OTHER;
    if (title_buf[0] != "P" || title_buf[1] != "U" || title_buf[2] != "W" ||
        title_buf[3] != "V") return ST_OTHER;
    case (title_buf[4])
      "0":     return ST_PUWV0;
      "E":     return ST_PUWVE;
      "7":     return ST_PUWV7;
      "4":     return ST_PUWV4;
      "3":     return ST_PUWV3;
      default: return ST_OTHER;
    endcase
  endfunction

  task automatic open_sentence();
    sent_phase     = PH_BODY;
    run_xor        = 8'd0;
    title_cnt      = 0;
    commas         = 0;
    at_field_start = 1'b0;
    field1_digit   = 4'd0;
    field2_digit   = 4'd0;
    hi_nibble      = 5'd0;
    for (int i = 0; i < TITLE_LEN; i++) title_buf[i] = 8'd0;
  endtask

  // Advance the tracker by one accepted byte; queue a result on the last digit
  task automatic follow_sentence_byte(input logic [7:0] c);
    nsc_result_t r;
    logic [4:0]  lo;
    logic [7:0]  rsum;
    bit          good;
    if (c == CH_DOLLAR) begin
      open_sentence();
    end else begin
      case (sent_phase)
        PH_BODY: begin
          if (c == CH_STAR) begin
            sent_phase = PH_HEX1;
          end else begin
            run_xor ^= c;
            if (title_cnt < TITLE_LEN) begin
              title_buf[title_cnt] = c;
              title_cnt++;
            end
            // first character of a field: a comma leaves the digit at zero
            if (at_field_start) begin
              if (c != CH_COMMA) begin
                if (commas == 1) field1_digit = digit_of(c);
                else field2_digit = digit_of(c);
              end
              at_field_start = 1'b0;
            end
            if (c == CH_COMMA && commas < 2) begin
              commas++;
              at_field_start = 1'b1;
            end
          end
        end
        PH_HEX1: begin
          hi_nibble  = nibble_of(c);
          sent_phase = PH_HEX2;
        end
        PH_HEX2: begin
          lo   = nibble_of(c);
          rsum = {hi_nibble[3:0], lo[3:0]};
          good = !hi_nibble[4] && !lo[4] && (rsum == run_xor);
          r.sentence_type = title_type();
          r.checksum_ok   = good;
          r.computed_sum  = run_xor;
          r.received_sum  = rsum;
          r.first_digit   = field1_digit;
          r.second_digit  = field2_digit;
          r.type_count    = 16'd0;
          // bump the counter of this type on a good checksum; PUWV0 needs command 2
          case (r.sentence_type)
            ST_PUWV0: begin
              if (good && field1_digit == 4'd2) cmd2_count++;
              r.type_count = 16'(cmd2_count);
            end
            ST_PUWV4: begin
              if (good) puwv4_count++;
              r.type_count = 16'(puwv4_count);
            end
            ST_PUWV3: begin
              if (good) puwv3_count++;
              r.type_count = 16'(puwv3_count);
            end
            default: ;
          endcase
          expected_sentences.push_back(r);
          sent_phase = PH_IDLE;
        end
        default: sent_phase = PH_IDLE;
      endcase
    end
  endtask

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one beat and hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = src_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    total_bytes++;
    if (sent_phase != PH_IDLE || b == CH_DOLLAR) live_bytes++;
    follow_sentence_byte(b);
  endtask

  task automatic send_raw(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s.getc(i));
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CH_ZERO + 8'(n);
    return CH_UPPER_A + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] lower_hex(input logic [7:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return c + CASE_SHIFT;
    return c;
  endfunction

  // Any byte that does not frame a sentence
  function automatic logic [7:0] body_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_DOLLAR || c == CH_STAR);
    return c;
  endfunction

  // A checksum digit that is not uppercase hex and does not restart
  function automatic logic [7:0] junk_digit();
    logic [7:0] c;
    logic [4:0] v;
    do begin
      c = 8'($urandom_range(0, 255));
      v = nibble_of(c);
    end while (!v[4] || c == CH_DOLLAR);
    return c;
  endfunction

  // Send frame_buf as a full sentence with a checksum of the given kind
  task automatic send_frame(input sum_mode_t mode);
    logic [7:0] sum;
    logic [7:0] hi;
    logic [7:0] lo;
    sum = 8'd0;
    for (int i = 0; i < frame_len; i++) sum ^= frame_buf[i];
    hi = hex_char(sum[7:4]);
    lo = hex_char(sum[3:0]);
    case (mode)
      CS_WRONG: lo = hex_char(sum[3:0] ^ 4'($urandom_range(1, 15)));
      CS_LOWER: begin
        hi = lower_hex(hi);
        lo = lower_hex(lo);
      end
      CS_JUNK: begin
        if ($urandom_range(0, 1) == 0) hi = junk_digit();
        else lo = junk_digit();
      end
      default: ;
    endcase
    send_byte(CH_DOLLAR);
    for (int i = 0; i < frame_len; i++) send_byte(frame_buf[i]);
    send_byte(CH_STAR);
    send_byte(hi);
    send_byte(lo);
  endtask

  task automatic send_text(input string s, input sum_mode_t mode);
    frame_len = s.len();
    for (int i = 0; i < frame_len; i++) frame_buf[i] = s.getc(i);
    send_frame(mode);
  endtask

  task automatic add_frame_byte(input logic [7:0] c);
    frame_buf[frame_len] = c;
    frame_len++;
  endtask

  function automatic logic [7:0] field_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      if ($urandom_range(0, 2) == 0) return CH_ZERO + 8'd2;
      return CH_ZERO + 8'($urandom_range(0, 9));
    end
    if (r < 72) return CH_COMMA;
    if (r < 88) return CH_UPPER_A + 8'($urandom_range(0, 25));
    return body_byte();
  endfunction

  // Build a random sentence body: mostly known titles, some near misses
  task automatic make_random_frame();
    int    r;
    int    n;
    string pick;
    frame_len = 0;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      pick = title_text[$urandom_range(0, 4)];
      for (int i = 0; i < TITLE_LEN; i++) add_frame_byte(pick.getc(i));
      if (r >= 70) frame_buf[$urandom_range(0, TITLE_LEN - 1)] = body_byte();
    end else begin
      n = $urandom_range(0, TITLE_LEN - 1);
      for (int i = 0; i < n; i++) add_frame_byte(CH_UPPER_A + 8'($urandom_range(0, 25)));
    end
    n = $urandom_range(0, 4);
    for (int f = 0; f < n; f++) begin
      add_frame_byte(CH_COMMA);
      repeat ($urandom_range(0, 3)) add_frame_byte(field_byte());
    end
  endtask

  function automatic sum_mode_t pick_sum_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return CS_GOOD;
    if (r < 90) return CS_WRONG;
    if (r < 95) return CS_LOWER;
    return CS_JUNK;
  endfunction

  // ---------------------------------------------------------------------
  // Receiver: random stalls plus an on-demand long hold
  // ---------------------------------------------------------------------
  initial begin : sink_model
    int run_left;
    int hold_left;
    bit stalling;
    run_left  = 0;
    hold_left = 0;
    stalling  = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!sink_idle_on) begin
        out_stall <= 1'b0;
      end else begin
        if (run_left <= 0) begin
          stalling = ($urandom_range(0, 99) < 35);
          run_left = stalling ? pick_gap() : $urandom_range(1, 12);
          if (run_left == 0) begin
            stalling = 1'b0;
            run_left = 1;
          end
        end
        out_stall <= stalling;
        run_left--;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    nsc_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_sentences.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("cycle %0d: result beat with nothing expected (type %0d sum %02h)",
                   cycle_count, sentence_type, computed_sum);
      end else begin
        want = expected_sentences.pop_front();
        type_hits[want.sentence_type]++;
        if (want.checksum_ok) good_seen++;
        if (want.sentence_type !== sentence_type || want.checksum_ok !== checksum_ok ||
            want.computed_sum !== computed_sum || want.received_sum !== received_sum ||
            want.first_digit !== first_digit || want.second_digit !== second_digit ||
            want.type_count !== type_count) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $write("cycle %0d exp/got: type %0d/%0d ok %0b/%0b csum %02h/%02h ",
                   cycle_count, want.sentence_type, sentence_type,
                   want.checksum_ok, checksum_ok, want.computed_sum, computed_sum);
            $display("rsum %02h/%02h d1 %0d/%0d d2 %0d/%0d count %0d/%0d",
                     want.received_sum, received_sum, want.first_digit, first_digit,
                     want.second_digit, second_digit, want.type_count, type_count);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Drop bytes outside a sentence
  task automatic test_idle_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_STAR);
    send_byte(CH_COMMA);
    send_raw("PUWV4,1*00");
  endtask

  task automatic test_known_titles();
    send_text("PUWV0,2,9", CS_GOOD);
    send_text("PUWV0,1,0", CS_GOOD);
    send_text("PUWVE,0,0", CS_GOOD);
    send_text("PUWV7,3,4", CS_GOOD);
    send_text("PUWV4,5,6", CS_GOOD);
    send_text("PUWV3,7,8", CS_GOOD);
    send_text("PUWV4", CS_GOOD);
  endtask

  // Unknown titles and titles cut short by the star
  task automatic test_other_titles();
    send_text("GPGGA,1,2", CS_GOOD);
    send_text("PUWV9,2,2", CS_GOOD);
    send_text("PUWV", CS_GOOD);
    send_text("PUW", CS_GOOD);
    send_text("", CS_GOOD);
  endtask

  task automatic test_field_digits();
    send_text("PUWV3,,5", CS_GOOD);
    send_text("PUWV3,9,", CS_GOOD);
    send_text("PUWV0,A,B", CS_GOOD);
    send_text("PUWV0,2", CS_GOOD);
    send_text("PUWV0,2,3,4", CS_GOOD);
    send_text("PUWV4,0,9", CS_GOOD);
    send_text("PU,V4,7,1", CS_GOOD);
  endtask

  // Wrong sums, lowercase and non-hex digits, extreme received values
  task automatic test_checksum_faults();
    send_text("PUWV4,1,1", CS_WRONG);
    send_text("PUWV3,2,2", CS_LOWER);
    send_text("PUWV0,2,2", CS_JUNK);
    send_raw("$PUWV4*ff");
    send_raw("$PUWV3*G0");
    send_raw("$PUWV0,2*");
    send_byte(8'hFF);
    send_byte(8'h00);
    send_raw("$*FF");
    send_raw("$*00");
  endtask

  // Restart on a dollar in the body and in either checksum digit
  task automatic test_restarts();
    send_raw("$PUWV3,1,");
    send_text("PUWV3,4,4", CS_GOOD);
    send_raw("$PUWV4*");
    send_text("PUWV4,1,2", CS_GOOD);
    send_raw("$PUWV4*1");
    send_text("PUWV0,2,1", CS_GOOD);
  endtask

  task automatic test_extreme_bytes();
    logic [7:0] ext [8];
    ext = '{8'h00, 8'hFF, 8'h80, 8'h7F, CH_COMMA, 8'hFE, CH_COMMA, 8'h01};
    frame_len = 8;
    for (int i = 0; i < 8; i++) frame_buf[i] = ext[i];
    send_frame(CS_GOOD);
  endtask

  // Back-to-back beats with no idling on either side
  task automatic test_steady_flow();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    repeat (10) begin
      make_random_frame();
      send_frame(pick_sum_mode());
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // Hold the receiver off long enough for the input side to back up
  task automatic test_backpressure();
    src_idle_on  = 1'b0;
    hold_request = LONG_HOLD;
    repeat (8) send_text("PUWV4,1,2", CS_GOOD);
    src_idle_on = 1'b1;
  endtask

  // Mostly well-formed sentences, plus broken frames and noise
  task automatic test_random_stream();
    int r;
    int n;
    int stop_at;
    stop_at = live_bytes + RANDOM_BYTES;
    while (live_bytes < stop_at) begin
      r = $urandom_range(0, 99);
      make_random_frame();
      if (r < 80) begin
        send_frame(pick_sum_mode());
      end else if (r < 90) begin
        n = $urandom_range(0, frame_len);
        send_byte(CH_DOLLAR);
        for (int i = 0; i < n; i++) send_byte(frame_buf[i]);
        if ($urandom_range(0, 1) == 1) begin
          send_byte(CH_STAR);
          if ($urandom_range(0, 1) == 1) send_byte(hex_char(4'($urandom_range(0, 15))));
        end
      end else begin
        repeat ($urandom_range(1, 12)) begin
          n = $urandom_range(0, 99);
          if (n < 10) send_byte(CH_DOLLAR);
          else if (n < 20) send_byte(CH_STAR);
          else if (n < 30) send_byte(CH_COMMA);
          else if (n < 45) send_byte(hex_char(4'($urandom_range(0, 15))));
          else send_byte(8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    rx_byte      <= 8'd0;
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    hold_request = 0;
    total_bytes  = 0;
    live_bytes   = 0;
    results_seen = 0;
    good_seen    = 0;
    mismatches   = 0;
    for (int i = 0; i < 6; i++) type_hits[i] = 0;
    open_sentence();
    sent_phase  = PH_IDLE;
    cmd2_count  = '0;
    puwv4_count = '0;
    puwv3_count = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_idle_bytes();
    test_known_titles();
    test_other_titles();
    test_field_digits();
    test_checksum_faults();
    test_restarts();
    test_extreme_bytes();
    test_steady_flow();
    test_backpressure();
    test_random_stream();

    // Drain outstanding results
    in_valid <= 1'b0;
    while (expected_sentences.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d bytes (%0d inside sentences), %0d result beats, %0d good sums.",
             total_bytes, live_bytes, results_seen, good_seen);
    $display("By type: PUWV0 %0d, PUWVE %0d, PUWV7 %0d, PUWV4 %0d, PUWV3 %0d, other %0d.",
             type_hits[0], type_hits[1], type_hits[2], type_hits[3], type_hits[4],
             type_hits[5]);
    if (mismatches == 0 && expected_sentences.size() == 0) begin
      $display("nmea_sentence_checker: match");
    end else begin
      $display("%0d bad result beats, %0d results never arrived", mismatches,
               expected_sentences.size());
      $display("nmea_sentence_checker: mismatch");
    end
    $finish;
  end

endmodule

// ===== nmea_sentence_checker.f =====
rtl/core/nsc_pkg.sv
rtl/core/nsc_in_reg.sv
rtl/core/nsc_parser.sv
rtl/core/nsc_out_reg.sv
rtl/core/nmea_sentence_checker.sv
rtl/core/nsc_checker.sv
tb/tb_nmea_sentence_checker.sv
